/* hw/rtl/utc_time_sync_stamper_core_defines.svh */
// Assertion macros shared by the time sync stamper RTL.
`ifndef UTC_TIME_SYNC_STAMPER_CORE_DEFINES_SVH
`define UTC_TIME_SYNC_STAMPER_CORE_DEFINES_SVH

// Same-cycle implication, checked on clk_i, off while rst_ni is low
`define UTCTS_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk_i, off while rst_ni is low
`define UTCTS_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/utcts_pkg.sv */
// Types, constants and the month table of the time sync stamper.
`timescale 1ns / 1ps
package utcts_pkg;

  // Field widths
  localparam int unsigned YEAR_W   = 14;
  localparam int unsigned EPOCH_W  = 38;
  localparam int unsigned TIMER_W  = 63;
  localparam int unsigned VALUE_W  = 64;

  // Shared multiply-add operand widths
  localparam int unsigned MAC_A_W  = 41;
  localparam int unsigned MAC_B_W  = 19;

  // Configuration reset values
  localparam logic [YEAR_W-1:0]  MIN_YEAR_RST  = 14'd2020;
  localparam logic [EPOCH_W-1:0] MIN_EPOCH_RST = 38'd1577836800;

  // Arithmetic constants
  localparam int unsigned US_PER_MS     = 1000;
  localparam int unsigned DAYS_PER_ERA  = 146097;
  localparam int unsigned DAYS_TO_EPOCH = 719468;
  localparam int unsigned SEC_PER_DAY   = 86400;
  localparam int unsigned ERA_RECIP     = 41944;  // ceil(2^24 / 400)
  localparam int unsigned ERA_SHIFT     = 24;

  // Operation codes
  typedef enum logic [1:0] {
    OP_CAL   = 2'd0,
    OP_EPOCH = 2'd1,
    OP_STAMP = 2'd2,
    OP_NONE  = 2'd3
  } utcts_op_e;

  // Configuration register indexes
  typedef enum logic {
    REG_MIN_YEAR  = 1'b0,
    REG_MIN_EPOCH = 1'b1
  } utcts_reg_e;

  typedef struct packed {
    logic [1:0]          opcode;
    logic [YEAR_W-1:0]   year;
    logic [3:0]          month;
    logic [4:0]          day;
    logic [4:0]          hour;
    logic [5:0]          minute;
    logic [5:0]          second;
    logic [EPOCH_W-1:0]  epoch_seconds;
    logic [TIMER_W-1:0]  timer_us;
  } utcts_in_t;

  typedef struct packed {
    logic                       accepted;
    logic                       synced;
    logic signed [VALUE_W-1:0]  value_ms;
  } utcts_out_t;

  // Days from March 1 to the first of the month: (153 * shifted_month + 2) / 5
  function automatic logic [8:0] month_days(input logic [3:0] month);
    logic [8:0] days;
    case (month)
      4'd0:    days = 9'd275;
      4'd1:    days = 9'd306;
      4'd2:    days = 9'd337;
      4'd3:    days = 9'd0;
      4'd4:    days = 9'd31;
      4'd5:    days = 9'd61;
      4'd6:    days = 9'd92;
      4'd7:    days = 9'd122;
      4'd8:    days = 9'd153;
      4'd9:    days = 9'd184;
      4'd10:   days = 9'd214;
      4'd11:   days = 9'd245;
      4'd12:   days = 9'd275;
      4'd13:   days = 9'd306;
      4'd14:   days = 9'd337;
      default: days = 9'd367;
    endcase
    return days;
  endfunction

endpackage

/* hw/rtl/utcts_div1000.sv */
// Divider of the uptime timer by 1000 (microseconds to milliseconds), three chunk steps.
`timescale 1ns / 1ps
module utcts_div1000 (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [utcts_pkg::TIMER_W-1:0]  dividend_i,
  output logic                           busy_o,
  output logic [utcts_pkg::TIMER_W-1:0]  quot_o
);
  import utcts_pkg::*;

  // t / 1000 = (t >> 3) / 125; the shifted timer is cut into three 20-bit chunks
  localparam int unsigned X_W         = TIMER_W - 3;
  localparam int unsigned CHUNK_W     = 20;
  localparam int unsigned REM_W       = 7;
  localparam int unsigned V_W         = REM_W + CHUNK_W;
  localparam int unsigned RECIP_W     = 28;
  localparam int unsigned PROD_W      = V_W + RECIP_W;
  localparam int unsigned RECIP_SHIFT = 34;
  localparam logic [RECIP_W-1:0] RECIP_125 = 28'd137438954;  // ceil(2^34 / 125)
  localparam logic [1:0]         LAST_CHUNK = 2'd2;

  logic                 busy_q, busy_d;
  logic [1:0]           cnt_q, cnt_d;
  logic [REM_W-1:0]     rem_q, rem_d;
  logic [X_W-1:0]       x_q, x_d;
  logic [V_W-1:0]       v;
  logic [PROD_W-1:0]    prod;
  logic [CHUNK_W-1:0]   q_chunk;

  // One chunk per cycle, MSB first; quotient chunks shift in as dividend chunks shift out
  always_comb begin
    v       = {rem_q, x_q[X_W-1 -: CHUNK_W]};
    prod    = PROD_W'(v) * PROD_W'(RECIP_125);
    q_chunk = prod[RECIP_SHIFT +: CHUNK_W];
    busy_d  = busy_q;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    x_d     = x_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      x_d    = dividend_i[TIMER_W-1:3];
    end else if (busy_q) begin
      // remainder is below 128: v - 125*q taken mod 128 is v + 3*q
      rem_d = v[REM_W-1:0] + {q_chunk[REM_W-2:0], 1'b0} + q_chunk[REM_W-1:0];
      x_d   = {x_q[X_W-CHUNK_W-1:0], q_chunk};
      if (cnt_q == LAST_CHUNK) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    x_q   <= x_d;
  end

  assign busy_o = busy_q;
  assign quot_o = TIMER_W'(x_q);

endmodule

/* hw/rtl/utcts_mac.sv */
// Shared signed multiply-add unit: p = a * b + c + d, modulo 2^64.
`timescale 1ns / 1ps
module utcts_mac (
  input  logic signed [utcts_pkg::MAC_A_W-1:0]  a_i,
  input  logic signed [utcts_pkg::MAC_B_W-1:0]  b_i,
  input  logic signed [utcts_pkg::VALUE_W-1:0]  c_i,
  input  logic signed [utcts_pkg::VALUE_W-1:0]  d_i,
  output logic signed [utcts_pkg::VALUE_W-1:0]  p_o
);
  import utcts_pkg::*;

  localparam int unsigned PROD_W = MAC_A_W + MAC_B_W;

  logic signed [PROD_W-1:0] prod;

  // Product is sign-extended into the 64-bit sum
  assign prod = a_i * b_i;
  assign p_o  = VALUE_W'(prod) + c_i + d_i;

endmodule

/* hw/rtl/utc_time_sync_stamper_core.sv */
// Top level of the UTC time sync stamper: sequencer, state and configuration registers.
`timescale 1ns / 1ps
// Keeps a millisecond offset between the uptime timer and UTC epoch time. An item is
// taken when start is high and busy is low; each item gives exactly one result, shown
// for a single cycle with result_valid_o, and the receiver cannot stall it, so it must
// be captured on that cycle. A rejected sync or the unused opcode answers the cycle
// after start, with busy never raised. An accepted calendar sync holds busy for five
// calendar steps on the one shared multiply-add unit, one wait and one final
// multiply-add step, and strobes its result in the cycle busy drops. Accepted epoch
// syncs and stamps hold busy while the timer is divided by 1000 in three chunk steps,
// then for one wait and the final multiply-add step. A new item may be started in
// the result cycle. Configuration writes are always taken (cfg_ready_o is tied high)
// and should only happen while the block idles.
`include "utc_time_sync_stamper_core_defines.svh"
module utc_time_sync_stamper_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // command channel
  input  logic                             start,
  output logic                             busy,
  input  utcts_pkg::utcts_in_t             item_i,
  // result channel
  output logic                             result_valid_o,
  output utcts_pkg::utcts_out_t            result_o,
  // configuration write channel
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic                             cfg_index_i,
  input  logic [utcts_pkg::EPOCH_W-1:0]    cfg_data_i
);
  import utcts_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HM,
    S_HMS,
    S_YOE,
    S_ERA,
    S_SECS,
    S_WAIT,
    S_FINAL
  } state_e;

  localparam int unsigned HMS_W = 18;

  state_e                     state_q;
  logic [1:0]                 op_q;
  logic signed [14:0]         y_q;
  logic signed [6:0]          era_q;
  logic [8:0]                 yoe_q;
  logic signed [9:0]          doy_q;
  logic [4:0]                 hour_q;
  logic [5:0]                 minute_q;
  logic [5:0]                 second_q;
  logic signed [VALUE_W-1:0]  acc_q;
  logic [HMS_W-1:0]           hms_q;
  logic signed [VALUE_W-1:0]  offset_q;
  logic                       synced_q;
  logic                       res_valid_q;
  utcts_out_t                 res_q;
  logic [YEAR_W-1:0]          min_year_q;
  logic [EPOCH_W-1:0]         min_epoch_q;

  logic                       accept;
  logic                       div_start;
  logic                       div_busy;
  logic [TIMER_W-1:0]         quot;
  logic signed [14:0]         y_in;
  logic [29:0]                era_prod;
  logic signed [6:0]          era_in;
  logic signed [9:0]          doy_in;
  logic signed [15:0]         era_ext;
  logic signed [15:0]         era400;
  logic signed [15:0]         yoe_full;
  logic [1:0]                 yoe_c;
  logic signed [21:0]         c0;
  logic signed [VALUE_W-1:0]  quot_ext;
  logic signed [MAC_A_W-1:0]  mac_a;
  logic signed [MAC_B_W-1:0]  mac_b;
  logic signed [VALUE_W-1:0]  mac_c;
  logic signed [VALUE_W-1:0]  mac_d;
  logic signed [VALUE_W-1:0]  mac_p;

  assign accept      = start && !busy;
  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  // Calendar prep at accept: shifted year, era by reciprocal multiply, day of year
  always_comb begin
    y_in     = 15'($unsigned(item_i.year)) - 15'((item_i.month <= 4'd2) ? 1 : 0);
    era_prod = 30'($unsigned(y_in[13:0])) * 30'(ERA_RECIP);
    era_in   = y_in[14] ? -7'sd1 : 7'($unsigned(era_prod[29:ERA_SHIFT]));
    doy_in   = 10'(month_days(item_i.month)) + 10'(item_i.day) - 10'd1;
  end

  // Year of era: y - era * 400 by shift-add
  always_comb begin
    era_ext  = 16'(era_q);
    era400   = (era_ext <<< 8) + (era_ext <<< 7) + (era_ext <<< 4);
    yoe_full = 16'(y_q) - era400;
  end

  // Leap-day, day-of-year and epoch-offset terms folded into one addend
  always_comb begin
    if (yoe_q >= 9'd300) begin
      yoe_c = 2'd3;
    end else if (yoe_q >= 9'd200) begin
      yoe_c = 2'd2;
    end else if (yoe_q >= 9'd100) begin
      yoe_c = 2'd1;
    end else begin
      yoe_c = 2'd0;
    end
    c0 = 22'($unsigned(yoe_q[8:2])) - 22'(yoe_c) + 22'(doy_q) - 22'(DAYS_TO_EPOCH);
  end

  assign quot_ext = VALUE_W'(quot);

  // Operand select for the shared multiply-add unit
  always_comb begin
    mac_a = '0;
    mac_b = '0;
    mac_c = '0;
    mac_d = '0;
    case (state_q)
      S_HM: begin
        mac_a = MAC_A_W'(hour_q);
        mac_b = MAC_B_W'(60);
        mac_c = VALUE_W'(minute_q);
      end
      S_HMS: begin
        mac_a = acc_q[MAC_A_W-1:0];
        mac_b = MAC_B_W'(60);
        mac_c = VALUE_W'(second_q);
      end
      S_YOE: begin
        mac_a = MAC_A_W'(yoe_q);
        mac_b = MAC_B_W'(365);
        mac_c = VALUE_W'(c0);
      end
      S_ERA: begin
        mac_a = MAC_A_W'(era_q);
        mac_b = MAC_B_W'(DAYS_PER_ERA);
        mac_c = acc_q;
      end
      S_SECS: begin
        mac_a = acc_q[MAC_A_W-1:0];
        mac_b = MAC_B_W'(SEC_PER_DAY);
        mac_c = VALUE_W'(hms_q);
      end
      S_FINAL: begin
        if (op_q == OP_STAMP) begin
          mac_c = quot_ext;
          mac_d = offset_q;
        end else begin
          mac_a = acc_q[MAC_A_W-1:0];
          mac_b = MAC_B_W'(US_PER_MS);
          mac_c = -quot_ext;
        end
      end
      default: begin
        mac_a = '0;
      end
    endcase
  end

  utcts_mac u_mac (
    .a_i (mac_a),
    .b_i (mac_b),
    .c_i (mac_c),
    .d_i (mac_d),
    .p_o (mac_p)
  );

  // Divider runs for every stamp and for every sync that gets past the range check
  always_comb begin
    div_start = 1'b0;
    if (accept) begin
      case (item_i.opcode)
        OP_CAL:   div_start = (item_i.year >= min_year_q);
        OP_EPOCH: div_start = (item_i.epoch_seconds >= min_epoch_q);
        OP_STAMP: div_start = 1'b1;
        default:  div_start = 1'b0;
      endcase
    end
  end

  utcts_div1000 u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (item_i.timer_us),
    .busy_o     (div_busy),
    .quot_o     (quot)
  );

  // Sequencer, offset state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_NONE;
      y_q         <= '0;
      era_q       <= '0;
      yoe_q       <= '0;
      doy_q       <= '0;
      hour_q      <= '0;
      minute_q    <= '0;
      second_q    <= '0;
      acc_q       <= '0;
      hms_q       <= '0;
      offset_q    <= '0;
      synced_q    <= 1'b0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      res_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            op_q     <= item_i.opcode;
            y_q      <= y_in;
            era_q    <= era_in;
            doy_q    <= doy_in;
            hour_q   <= item_i.hour;
            minute_q <= item_i.minute;
            second_q <= item_i.second;
            acc_q    <= VALUE_W'(item_i.epoch_seconds);
            if (div_start) begin
              state_q <= (item_i.opcode == OP_CAL) ? S_HM : S_WAIT;
            end else begin
              // rejected sync or unused code: report held state right away
              res_valid_q    <= 1'b1;
              res_q.accepted <= 1'b0;
              res_q.synced   <= synced_q;
              res_q.value_ms <= offset_q;
            end
          end
        end
        S_HM: begin
          acc_q   <= mac_p;
          yoe_q   <= yoe_full[8:0];
          state_q <= S_HMS;
        end
        S_HMS: begin
          acc_q   <= mac_p;
          state_q <= S_YOE;
        end
        S_YOE: begin
          hms_q   <= acc_q[HMS_W-1:0];
          acc_q   <= mac_p;
          state_q <= S_ERA;
        end
        S_ERA: begin
          acc_q   <= mac_p;
          state_q <= S_SECS;
        end
        S_SECS: begin
          acc_q   <= mac_p;
          state_q <= S_WAIT;
        end
        S_WAIT: begin
          if (!div_busy) begin
            state_q <= S_FINAL;
          end
        end
        S_FINAL: begin
          res_valid_q    <= 1'b1;
          res_q.accepted <= 1'b1;
          res_q.value_ms <= mac_p;
          if (op_q == OP_STAMP) begin
            res_q.synced <= synced_q;
          end else begin
            offset_q     <= mac_p;
            synced_q     <= 1'b1;
            res_q.synced <= 1'b1;
          end
          state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_year_q  <= MIN_YEAR_RST;
      min_epoch_q <= MIN_EPOCH_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_MIN_YEAR:  min_year_q  <= cfg_data_i[YEAR_W-1:0];
        REG_MIN_EPOCH: min_epoch_q <= cfg_data_i;
        default:       min_year_q  <= min_year_q;
      endcase
    end
  end

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

  // Checks
  `UTCTS_ASSERT_IMP(a_result_when_idle, result_valid_o, !busy,
                    "result strobe while the sequencer is busy")
  `UTCTS_ASSERT_NXT(a_accept_progress, start && !busy, busy || result_valid_o,
                    "accepted item neither started work nor answered")
  `UTCTS_ASSERT_IMP(a_final_after_div, state_q == S_FINAL, !div_busy,
                    "final step taken before the millisecond quotient is ready")
  `UTCTS_ASSERT_NXT(a_synced_sticky, synced_q, synced_q,
                    "synced flag dropped without reset")

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the UTC time sync stamper core.
`timescale 1ns / 1ps
module testbench;
  import utcts_pkg::*;

  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int DRAIN_LIMIT = 2_000;
  localparam int IN_W = $bits(utcts_in_t);
  localparam longint EPOCH_MAX = (64'd1 << EPOCH_W) - 1;
  localparam longint YEAR_MAX = (64'd1 << YEAR_W) - 1;

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  utcts_in_t           item_i;
  logic                result_valid_o;
  utcts_out_t          result_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic                cfg_index_i;
  logic [EPOCH_W-1:0]  cfg_data_i;

  utc_time_sync_stamper_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .item_i         (item_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  // Predicted block state and configuration
  logic [YEAR_W-1:0]   min_year_cfg;
  logic [EPOCH_W-1:0]  min_epoch_cfg;
  logic [VALUE_W-1:0]  held_offset_ms;
  logic                held_synced;

  utcts_out_t pending_results[$];
  int mismatches;
  int cycle_count;
  int results_seen;
  int n_cal, n_epoch, n_stamp, n_refused, n_cfg_writes;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still expected", $time, pending_results.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Days since 1970-01-01 for a proleptic Gregorian date, eras by floor division
  function automatic longint days_since_epoch(longint y, longint m, longint d);
    longint era, yoe, doy, doe;
    if (m <= 2) y = y - 1;
    era = (y >= 0 ? y : y - 399) / 400;
    yoe = y - era * 400;
    doy = (153 * (m + (m > 2 ? -3 : 9)) + 2) / 5 + d - 1;
    doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    return era * 146097 + doe - 719468;
  endfunction

  // Offset held after a sync at epoch second secs with uptime timer t
  function automatic logic [VALUE_W-1:0] sync_offset(longint secs, logic [TIMER_W-1:0] t);
    logic [63:0] ms, t_ms;
    ms   = secs * 1000;
    t_ms = {1'b0, t} / 64'd1000;
    return ms - t_ms;
  endfunction

  // Expected result of one item; updates the predicted state
  task automatic stamp_or_sync(input utcts_in_t it, output utcts_out_t res);
    longint secs;
    res.accepted = 1'b0;
    case (utcts_op_e'(it.opcode))
      OP_CAL: begin
        n_cal++;
        if (it.year >= min_year_cfg) begin
          secs = days_since_epoch(longint'(it.year), longint'(it.month), longint'(it.day))
                 * 86400 + longint'(it.hour) * 3600 + longint'(it.minute) * 60
                 + longint'(it.second);
          held_offset_ms = sync_offset(secs, it.timer_us);
          held_synced    = 1'b1;
          res.accepted   = 1'b1;
        end
        res.value_ms = held_offset_ms;
      end
      OP_EPOCH: begin
        n_epoch++;
        if (it.epoch_seconds >= min_epoch_cfg) begin
          held_offset_ms = sync_offset(longint'(it.epoch_seconds), it.timer_us);
          held_synced    = 1'b1;
          res.accepted   = 1'b1;
        end
        res.value_ms = held_offset_ms;
      end
      OP_STAMP: begin
        n_stamp++;
        res.value_ms = ({1'b0, it.timer_us} / 64'd1000) + held_offset_ms;
        res.accepted = 1'b1;
      end
      default: res.value_ms = held_offset_ms;
    endcase
    if (!res.accepted) n_refused++;
    res.synced = held_synced;
  endtask

  // Result checker: every strobed result against the oldest expectation
  always @(posedge clk_i) begin
    utcts_out_t exp_res;
    if (rst_ni && result_valid_o) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result acc=%0b sync=%0b value=%0d", $time,
                 result_o.accepted, result_o.synced, result_o.value_ms);
        mismatches++;
      end else begin
        exp_res = pending_results.pop_front();
        if (result_o.accepted !== exp_res.accepted) begin
          $display("%0t: accepted expected %0b actual %0b", $time,
                   exp_res.accepted, result_o.accepted);
          mismatches++;
        end
        if (result_o.synced !== exp_res.synced) begin
          $display("%0t: synced expected %0b actual %0b", $time,
                   exp_res.synced, result_o.synced);
          mismatches++;
        end
        if (result_o.value_ms !== exp_res.value_ms) begin
          $display("%0t: value_ms expected %0d actual %0d", $time,
                   exp_res.value_ms, result_o.value_ms);
          mismatches++;
        end
      end
    end
  end

  // Random timer: mostly full range, with zero, max and small values mixed in
  function automatic logic [TIMER_W-1:0] random_timer();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      2, 3:    return TIMER_W'(raw[19:0]);
      default: return raw[TIMER_W-1:0];
    endcase
  endfunction

  // Item with every field random bits
  function automatic utcts_in_t random_fields();
    utcts_in_t it;
    it = IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom});
    it.timer_us = random_timer();
    return it;
  endfunction

  function automatic utcts_in_t cal_item(longint y, int mo, int d, int h, int mi, int s,
                                         logic [TIMER_W-1:0] t);
    utcts_in_t it;
    it = random_fields();
    it.opcode = OP_CAL;
    it.year = YEAR_W'(y);
    it.month = 4'(mo);
    it.day = 5'(d);
    it.hour = 5'(h);
    it.minute = 6'(mi);
    it.second = 6'(s);
    it.timer_us = t;
    return it;
  endfunction

  function automatic utcts_in_t op_item(utcts_op_e op, longint es, logic [TIMER_W-1:0] t);
    utcts_in_t it;
    it = random_fields();
    it.opcode = op;
    it.epoch_seconds = EPOCH_W'(es);
    it.timer_us = t;
    return it;
  endfunction

  // One command transfer; the expectation is formed at the accepting edge
  task automatic send_item(input utcts_in_t it);
    utcts_out_t res;
    @(negedge clk_i);
    start  <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy);
    stamp_or_sync(it, res);
    pending_results.push_back(res);
  endtask

  // Random sender gaps, short ones mostly and a few spanning a whole item
  task automatic pace_sender(input bit no_idle);
    int gap;
    if (no_idle || $urandom_range(0, 99) >= 26) return;
    gap = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
    repeat (gap) begin
      @(negedge clk_i);
      start  <= 1'b0;
      item_i <= random_fields();
    end
  endtask

  // Stop sending and wait for every expected result, then let the block settle
  task automatic drain_results(input int settle);
    int waited;
    waited = 0;
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    if (pending_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_results.size());
      mismatches++;
      pending_results.delete();
    end
    repeat (settle) @(posedge clk_i);
  endtask

  // One configuration transfer
  task automatic write_config(input utcts_reg_e idx, input logic [EPOCH_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == REG_MIN_YEAR) min_year_cfg = data[YEAR_W-1:0];
    else min_epoch_cfg = data;
    n_cfg_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Drain, then set both limits; the year register is written with junk above its 14 bits
  task automatic set_limits(input longint min_year, input longint min_epoch);
    logic [EPOCH_W-1:0] year_word;
    drain_results(4);
    year_word = EPOCH_W'({$urandom, $urandom});
    year_word[YEAR_W-1:0] = YEAR_W'(min_year);
    write_config(REG_MIN_YEAR, year_word);
    write_config(REG_MIN_EPOCH, EPOCH_W'(min_epoch));
  endtask

  // Reset limits: both boundaries, unsynced stamp, unused opcode, leap second
  task automatic test_reset_state();
    send_item(op_item(OP_STAMP, 0, 63'd123456789));
    send_item(op_item(OP_NONE, 0, random_timer()));
    send_item(cal_item(2019, 12, 31, 23, 59, 59, 63'd5000000));
    send_item(cal_item(2020, 1, 1, 0, 0, 0, 63'd7000123));
    send_item(op_item(OP_EPOCH, 1577836799, 63'd42));
    send_item(op_item(OP_EPOCH, 1577836800, '1));
    send_item(op_item(OP_STAMP, 0, '0));
    send_item(cal_item(2024, 2, 29, 12, 30, 60, 63'd999999999));
  endtask

  // Field extremes with both limits at zero
  task automatic test_field_extremes();
    set_limits(0, 0);
    send_item(cal_item(0, 1, 1, 0, 0, 0, 63'd1));
    send_item(cal_item(0, 0, 0, 31, 63, 63, '0));
    send_item(cal_item(YEAR_MAX, 15, 31, 31, 63, 63, '1));
    send_item(cal_item(1970, 13, 14, 0, 0, 0, random_timer()));
    send_item(cal_item(400, 3, 1, 0, 0, 0, random_timer()));
    send_item(cal_item(399, 2, 28, 23, 59, 60, random_timer()));
    send_item(op_item(OP_EPOCH, 0, '0));
    send_item(op_item(OP_EPOCH, EPOCH_MAX, '1));
    send_item(op_item(OP_STAMP, 0, '1));
    send_item({2'(OP_NONE), {(YEAR_W + 26 + EPOCH_W + TIMER_W){1'b1}}});
  endtask

  // Limits at their maximum: only the top year and second pass
  task automatic test_limit_extremes();
    set_limits(YEAR_MAX, EPOCH_MAX);
    send_item(cal_item(YEAR_MAX - 1, 12, 31, 23, 59, 59, random_timer()));
    send_item(cal_item(YEAR_MAX, 1, 1, 0, 0, 0, random_timer()));
    send_item(op_item(OP_EPOCH, EPOCH_MAX - 1, random_timer()));
    send_item(op_item(OP_EPOCH, EPOCH_MAX, random_timer()));
    send_item(op_item(OP_STAMP, 0, random_timer()));
  endtask

  // Random traffic: stamps and syncs, the syncs mostly plausible and around the limits, some raw noise
  task automatic test_random_traffic(input longint min_year, input longint min_epoch,
                                     input int n_items, input bit no_idle);
    utcts_in_t it;
    longint v;
    int pick;
    set_limits(min_year, min_epoch);
    repeat (n_items) begin
      it = random_fields();
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        it.opcode = OP_CAL;
        if ($urandom_range(0, 4) != 0) begin
          v = longint'(min_year_cfg) - 3 + $urandom_range(0, 60);
          if (v < 0) v = 0;
          if (v > YEAR_MAX) v = YEAR_MAX;
          it.year = YEAR_W'(v);
          it.month = 4'($urandom_range(1, 12));
          it.day = 5'($urandom_range(1, 31));
          it.hour = 5'($urandom_range(0, 23));
          it.minute = 6'($urandom_range(0, 59));
          it.second = 6'($urandom_range(0, 60));
        end
      end else if (pick < 55) begin
        it.opcode = OP_EPOCH;
        if ($urandom_range(0, 4) != 0) begin
          if ($urandom_range(0, 1) == 0) v = longint'(min_epoch_cfg) - 5 + $urandom_range(0, 1000);
          else v = longint'(min_epoch_cfg) + longint'($urandom);
          if (v < 0) v = 0;
          if (v > EPOCH_MAX) v = EPOCH_MAX;
          it.epoch_seconds = EPOCH_W'(v);
        end
      end else if (pick < 95) begin
        it.opcode = OP_STAMP;
      end else begin
        it.opcode = OP_NONE;
      end
      send_item(it);
      pace_sender(no_idle);
    end
  endtask

  // Test sequence
  initial begin
    rst_ni = 1'b0;
    start <= 1'b0;
    item_i <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= REG_MIN_YEAR;
    cfg_data_i <= '0;
    min_year_cfg = MIN_YEAR_RST;
    min_epoch_cfg = MIN_EPOCH_RST;
    held_offset_ms = '0;
    held_synced = 1'b0;
    mismatches = 0;
    results_seen = 0;
    n_cal = 0;
    n_epoch = 0;
    n_stamp = 0;
    n_refused = 0;
    n_cfg_writes = 0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_state();
    test_field_extremes();
    test_limit_extremes();
    test_random_traffic(2020, 1577836800, 400, 1'b0);
    test_random_traffic(0, 0, 300, 1'b1);
    test_random_traffic($urandom_range(1970, 2100), longint'($urandom), 400, 1'b0);
    test_random_traffic(YEAR_MAX, EPOCH_MAX, 250, 1'b0);
    test_random_traffic($urandom_range(0, YEAR_MAX), {$urandom, $urandom} & EPOCH_MAX,
                        300, 1'b0);
    test_random_traffic(1900, 946684800, 300, 1'b0);
    drain_results(80);

    $display("Checked %0d results: %0d calendar syncs, %0d epoch syncs, %0d stamps",
             results_seen, n_cal, n_epoch, n_stamp);
    $display("%0d items refused or unused, %0d register writes, %0d mismatches",
             n_refused, n_cfg_writes, mismatches);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* utc_time_sync_stamper_core.f */
+incdir+hw/rtl
hw/rtl/utcts_pkg.sv
hw/rtl/utcts_div1000.sv
hw/rtl/utcts_mac.sv
hw/rtl/utc_time_sync_stamper_core.sv
tb/testbench.sv
